// ----- hw/rtl/slcg_pkg.sv -----
`default_nettype none
package slcg_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned FactorWidth = 17;
  localparam int unsigned NumSteps    = 16;
  localparam int unsigned StepWidth   = $clog2(NumSteps);
  localparam int unsigned AddrWidth   = 3;

  localparam logic [DataWidth-1:0] SeedReset = 32'd11372797;
  localparam logic [DataWidth-1:0] SpreadAdd = 32'h0000FFFF;
  localparam logic [DataWidth-1:0] SpreadReset = ((~SeedReset) >> 5) + SpreadAdd;

  // register indexes, decoded from paddr[2]
  localparam logic RegSeed = 1'b0;

  localparam logic [FactorWidth-1:0] FactorTable [2*NumSteps] = '{
    17'd19,    17'd8191,  17'd337,   17'd431,   17'd89,    17'd257,   17'd2833,  17'd353,
    17'd4649,  17'd673,   17'd193,   17'd449,   17'd9901,  17'd97,    17'd1777,  17'd2113,
    17'd65537, 17'd113,   17'd953,   17'd683,   17'd1321,  17'd26317, 17'd37171, 17'd1013,
    17'd1657,  17'd1103,  17'd13367, 17'd5419,  17'd1429,  17'd20857, 17'd241,   17'd101
  };

  typedef struct packed {
    logic                 busy;
    logic [DataWidth-1:0] multiplier;
    logic [DataWidth-1:0] increment;
  } coef_t;

endpackage
`default_nettype wire

// ----- hw/rtl/slcg_coef.sv -----
`default_nettype none
module slcg_coef (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire logic [slcg_pkg::DataWidth-1:0]  load_seed,
  input  wire logic [slcg_pkg::DataWidth-1:0]  seed,
  output slcg_pkg::coef_t                      coef
);
  import slcg_pkg::*;

  logic                 busy;
  logic [StepWidth-1:0] step;
  logic [DataWidth-1:0] spread;
  logic [DataWidth-1:0] inc;
  logic [DataWidth-1:0] mul;
  logic [DataWidth-1:0] inc_next;
  logic [DataWidth-1:0] mul_next;
  logic [DataWidth-1:0] inc_prod;
  logic [DataWidth-1:0] mul_prod;

  always_comb begin
    inc_prod = inc * DataWidth'(FactorTable[{1'b0, step}]);
    mul_prod = mul * DataWidth'(FactorTable[{1'b1, step}]);
    inc_next = seed[step] ? inc_prod : inc;
    mul_next = spread[{1'b1, step}] ? mul_prod : mul;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      step   <= '0;
      spread <= SpreadReset;
      inc    <= DataWidth'(1);
      mul    <= DataWidth'(2);
    end else if (load) begin
      busy   <= 1'b1;
      step   <= '0;
      spread <= ((~load_seed) >> 5) + SpreadAdd;
      inc    <= DataWidth'(1);
      mul    <= DataWidth'(2);
    end else if (busy) begin
      inc  <= inc_next;
      mul  <= mul_next;
      step <= step + StepWidth'(1);
      if (step == StepWidth'(NumSteps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // the accumulated multiplier stays even, so adding one sets bit 0
  assign coef.busy       = busy;
  assign coef.multiplier = {mul[DataWidth-1:1], 1'b1};
  assign coef.increment  = inc;

endmodule
`default_nettype wire

// ----- hw/rtl/slcg_core.sv -----
`default_nettype none
module slcg_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clear,
  input  wire slcg_pkg::coef_t                 coef,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_restart,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [slcg_pkg::DataWidth-1:0]       out_value
);
  import slcg_pkg::*;

  logic                 req_valid;
  logic                 req_restart;
  logic                 res_valid;
  logic [DataWidth-1:0] res_value;
  logic [DataWidth-1:0] current_value;
  logic                 advance;
  logic [DataWidth-1:0] base;
  logic [DataWidth-1:0] prod;
  logic [DataWidth-1:0] value_next;

  assign advance  = !res_valid || out_ready;
  assign in_ready = !coef.busy && (!req_valid || advance);

  always_comb begin
    base       = req_restart ? '0 : current_value;
    prod       = coef.multiplier * base;
    value_next = prod + coef.increment;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid     <= 1'b0;
      res_valid     <= 1'b0;
      current_value <= '0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= req_valid;
      end
      if (clear) begin
        current_value <= '0;
      end else if (advance && req_valid) begin
        current_value <= value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_restart <= in_restart;
    end
    if (advance && req_valid) begin
      res_value <= value_next;
    end
  end

  assign out_valid = res_valid;
  assign out_value = res_value;

endmodule
`default_nettype wire

// ----- hw/rtl/seeded_lcg_generator.sv -----
// an accepted request goes through a request and then a result register to m_tdata
// throughput: one transaction per cycle when not stalled by m_tready or a rebuild
// the step is one 32-bit multiply-add; after reset and after every seed write
// the coefficients are rebuilt by a 16-step multiply sequencer, with s_tready low
// reset clears the sequence state to zero and loads the seed 11372797
`default_nettype none
module seeded_lcg_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [0] restart
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [slcg_pkg::DataWidth-1:0]       m_tdata,   // [31:0] value
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [slcg_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import slcg_pkg::*;

  logic                 seed_wr;
  logic [DataWidth-1:0] seed;
  coef_t                coef;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == RegSeed);
  assign prdata  = (paddr[2] == RegSeed) ? seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SeedReset;
    end else if (seed_wr) begin
      seed <= pwdata;
    end
  end

  slcg_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .load      (seed_wr),
    .load_seed (pwdata),
    .seed      (seed),
    .coef      (coef)
  );

  slcg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .clear      (seed_wr),
    .coef       (coef),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_restart (s_tdata[0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
  import slcg_pkg::*;

  localparam int unsigned ITEM_TARGET = 460;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [2:0] ADDR_SEED = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam logic [31:0] SPREAD_OFFSET = 32'h0000FFFF;

  localparam logic [31:0] FACTORS [32] = '{
    32'd19,    32'd8191,  32'd337,   32'd431,   32'd89,    32'd257,   32'd2833,  32'd353,
    32'd4649,  32'd673,   32'd193,   32'd449,   32'd9901,  32'd97,    32'd1777,  32'd2113,
    32'd65537, 32'd113,   32'd953,   32'd683,   32'd1321,  32'd26317, 32'd37171, 32'd1013,
    32'd1657,  32'd1103,  32'd13367, 32'd5419,  32'd1429,  32'd20857, 32'd241,   32'd101
  };

  typedef enum logic [1:0] {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] data;
    bit          known;
    logic [31:0] value;
  } stim_row_t;

  // seed 0: increment 1, multiplier 2*5419+1 = 10839
  stim_row_t directed_rows [27] = '{
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h01,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'hFE,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'hFF,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'h00000000,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b1, 32'd1},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b1, 32'd10840},
    '{ROW_ITEM,  ADDR_SEED,   32'h01,         1'b1, 32'd1},
    '{ROW_ITEM,  ADDR_SEED,   32'hFE,         1'b1, 32'd10840},
    '{ROW_WRITE, ADDR_UNUSED, 32'hFFFFFFFF,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'hFFFFFFFF,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h01,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'h0000FFFF,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h80,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'hFFFF0000,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h7F,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'hAAAAAAAA,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_WRITE, ADDR_SEED,   32'h55555555,   1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0},
    '{ROW_ITEM,  ADDR_SEED,   32'h00,         1'b0, 32'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DataWidth-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  seeded_lcg_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // generator model state
  logic [31:0] seed_model;
  logic [31:0] lcg_x;
  logic [31:0] lcg_mul;
  logic [31:0] lcg_inc;

  logic [31:0] pending_values [$];
  int          error_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          seed_writes = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int          pattern_left = 0;
  int          pattern_mode = 0;

  task automatic flag_error(input string what, input logic [31:0] exp, input logic [31:0] act);
    error_count++;
    if (error_count <= 10) $display("mismatch on %s: expected %h, got %h", what, exp, act);
  endtask

  task automatic load_seed_model(input logic [31:0] s);
    logic [31:0] inc;
    logic [31:0] mul;
    logic [31:0] spread;
    inc = 32'd1;
    mul = 32'd2;
    spread = ((~s) >> 5) + SPREAD_OFFSET;
    for (int k = 0; k < 16; k++) if (s[k]) inc = inc * FACTORS[k];
    for (int k = 16; k < 32; k++) if (spread[k]) mul = mul * FACTORS[k];
    seed_model = s;
    lcg_inc = inc;
    lcg_mul = mul + 32'd1;
    lcg_x = '0;
  endtask

  function automatic logic [31:0] lcg_advance(input logic [7:0] req);
    if (req[0]) lcg_x = '0;
    lcg_x = lcg_mul * lcg_x + lcg_inc;
    return lcg_x;
  endfunction

  // offer one request transaction in bursts with random gaps
  task automatic offer_request(input logic [7:0] req, input bit known, input logic [31:0] value);
    int gap;
    logic [31:0] predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= req;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predicted = lcg_advance(req);
    pending_values.push_back(known ? value : predicted);
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // write a register, then read the seed back
  task automatic program_register(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_SEED) begin
      load_seed_model(data);
      seed_writes++;
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SEED;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== seed_model) flag_error("seed readback", seed_model, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // output side: checks values and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_values.size() == 0) flag_error("value with nothing pending", 'x, m_tdata);
        else if (m_tdata !== pending_values[0]) flag_error("value", pending_values[0], m_tdata);
        if (pending_values.size() != 0) void'(pending_values.pop_front());
      end
      if (pattern_left == 0) begin
        pattern_mode <= $urandom_range(0, 3);
        pattern_left <= $urandom_range(8, 64);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 200 && s_tvalid) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        case (pattern_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] seed_pick;
    logic [7:0]  req;
    int          n_items;
    int          phase;
    bit          paused_once;
    phase = 0;
    paused_once = 1'b0;
    load_seed_model(SeedReset);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        drain_and_settle();
        program_register(row.addr, row.data);
      end else begin
        offer_request(row.data[7:0], row.known, row.value);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      drain_and_settle();
      phase++;
      case ($urandom_range(0, 5))
        0: seed_pick = '0;
        1: seed_pick = '1;
        default: seed_pick = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) program_register(ADDR_UNUSED, $urandom);
      program_register(ADDR_SEED, seed_pick);
      n_items = $urandom_range(20, 80);
      for (int i = 0; i < n_items; i++) begin
        if (!paused_once && phase == 3 && i == n_items / 2) begin
          drain_and_settle();
          paused_once = 1'b1;
        end
        req = 8'($urandom);
        req[0] = ($urandom_range(0, 7) == 0);
        offer_request(req, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d requests and %0d checked values over %0d seed settings",
             items_sent, results_seen, seed_writes);
    $display("included restarts, ignored register writes, a long output stall and a full drain");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- seeded_lcg_generator.f -----
hw/rtl/slcg_pkg.sv
hw/rtl/slcg_coef.sv
hw/rtl/slcg_core.sv
hw/rtl/seeded_lcg_generator.sv
verif/testbench.sv
